// File: rtl/core/wmfa_pkg.sv
// ----------------------------------------------------------------------------
// wmfa_pkg
// Shared types and constants of the management frame anonymizer.
// ----------------------------------------------------------------------------
package wmfa_pkg;

  typedef enum logic [2:0] {
    KIND_NONE      = 3'd0,
    KIND_ASSOC_REQ = 3'd1,
    KIND_PROBE_REQ = 3'd2,
    KIND_BEACON    = 3'd3,
    KIND_WALK      = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    PH_ID   = 2'd0,
    PH_LEN  = 2'd1,
    PH_BODY = 2'd2
  } phase_t;

  localparam logic [1:0] TYPE_MGMT      = 2'd0;
  localparam logic [3:0] SUB_ASSOC_REQ  = 4'd0;
  localparam logic [3:0] SUB_PROBE_REQ  = 4'd4;
  localparam logic [3:0] SUB_PROBE_RESP = 4'd5;
  localparam logic [3:0] SUB_BEACON     = 4'd8;

  localparam int OFS_ASSOC_REQ = 28;
  localparam int OFS_PROBE_REQ = 24;
  localparam int OFS_BEACON    = 36;
  localparam int ADDR_START    = 4;
  localparam int FCS_BYTES     = 4;

  localparam logic [7:0] BCAST_BYTE = 8'hff;
  localparam logic [7:0] SSID_FILL  = 8'h58;
  localparam logic [7:0] SSID_ID    = 8'h00;

  localparam int QUEUE_DEPTH = 4;

  // Output bytes caused by one accepted input byte, first byte in data[0].
  typedef struct packed {
    logic [1:0]      count;
    logic            pkt_last;
    logic [2:0][7:0] data;
  } group_t;

endpackage

// File: rtl/core/wmfa_front.sv
// ----------------------------------------------------------------------------
// wmfa_front
// Tracks the packet position, parses the radiotap length and frame control,
// walks the information elements and forms the output bytes of each input.
// ----------------------------------------------------------------------------
module wmfa_front import wmfa_pkg::*; #(
  parameter int LENGTH_WIDTH = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [7:0]    data_byte,
  input  logic          first_byte,
  input  logic          last_byte,
  input  logic [15:0]   capture_length,
  input  logic          q_full,
  output logic          push,
  output group_t        push_group
);

  localparam int L = LENGTH_WIDTH;
  localparam int W = LENGTH_WIDTH + 2;
  localparam logic [L-1:0] LMAX = {L{1'b1}};

  function automatic logic [W-1:0] walk_ofs(kind_t k);
    logic [W-1:0] o;
    o = W'(OFS_BEACON);
    unique case (k)
      KIND_ASSOC_REQ: o = W'(OFS_ASSOC_REQ);
      KIND_PROBE_REQ: o = W'(OFS_PROBE_REQ);
      default:        o = W'(OFS_BEACON);
    endcase
    return o;
  endfunction

  logic [L-1:0] pos, pos_next;
  logic [L-1:0] pkt_len, pkt_len_next;
  logic [L-1:0] rt_len, rt_len_next;
  kind_t        kind, kind_next;
  phase_t       phase, phase_next;
  logic         is_ssid, is_ssid_next;
  logic [7:0]   elem_rem, elem_rem_next;
  logic [L-1:0] region, region_next;
  logic         all_ones, all_ones_next;
  logic [7:0]   held0, held0_next;
  logic [7:0]   held1, held1_next;

  logic         accept;
  logic [L-1:0] pend_r;
  logic [1:0]   n_pre;
  logic [L-1:0] p;
  logic [L-1:0] rt_new;
  logic         cls_en;
  logic [7:0]   fcl;
  kind_t        cls_kind;
  logic [W-1:0] need;
  logic [L-1:0] r;
  logic         ff;
  logic [7:0]   ob;
  logic [1:0]   main_n;
  logic [7:0]   m0, m1, m2;
  group_t       grp;

  assign accept   = in_valid && !in_stall;
  assign in_stall = q_full;

  always_comb begin
    pos_next      = pos;
    pkt_len_next  = pkt_len;
    rt_len_next   = rt_len;
    kind_next     = kind;
    phase_next    = phase;
    is_ssid_next  = is_ssid;
    elem_rem_next = elem_rem;
    region_next   = region;
    all_ones_next = all_ones;
    held0_next    = held0;
    held1_next    = held1;
    n_pre         = 2'd0;
    pend_r        = pos - rt_len;
    rt_new        = L'({data_byte, rt_len[7:0]});
    cls_en        = 1'b0;
    fcl           = data_byte;
    cls_kind      = KIND_NONE;
    need          = '0;
    r             = '0;
    ff            = (data_byte == BCAST_BYTE);
    ob            = data_byte;
    main_n        = 2'd1;
    m0            = data_byte;
    m1            = 8'd0;
    m2            = 8'd0;
    grp           = '0;

    // Address bytes still held when a new packet starts are released as zero.
    if (first_byte) begin
      if (pos != LMAX && {2'b0, pos} >= {2'b0, rt_len} + W'(ADDR_START) &&
          pend_r[L-1:5] == '0) begin
        if (pend_r[4:0] == 5'd8 || pend_r[4:0] == 5'd20) begin
          n_pre = 2'd1;
        end else if (pend_r[4:0] == 5'd9 || pend_r[4:0] == 5'd21) begin
          n_pre = 2'd2;
        end
      end
      pos_next      = '0;
      pkt_len_next  = L'(capture_length);
      rt_len_next   = '0;
      kind_next     = KIND_NONE;
      phase_next    = PH_ID;
      all_ones_next = 1'b1;
    end
    p = pos_next;

    if (p != LMAX) begin
      if (p == L'(2)) begin
        rt_len_next = L'(data_byte);
      end
      if (p == L'(3)) begin
        rt_len_next = rt_new;
        if (rt_new == L'(2)) begin
          cls_en = 1'b1;
          fcl    = 8'd2;
        end else if (rt_new == L'(3)) begin
          cls_en = 1'b1;
        end else begin
          kind_next = KIND_NONE;
        end
      end
      if (p >= L'(4) && p == rt_len_next) begin
        cls_en = 1'b1;
      end

      if (cls_en) begin
        if (fcl[3:2] == TYPE_MGMT) begin
          if (fcl[7:4] == SUB_ASSOC_REQ) begin
            cls_kind = KIND_ASSOC_REQ;
          end else if (fcl[7:4] == SUB_PROBE_REQ) begin
            cls_kind = KIND_PROBE_REQ;
          end else if (fcl[7:4] == SUB_PROBE_RESP || fcl[7:4] == SUB_BEACON) begin
            cls_kind = KIND_BEACON;
          end
        end
        kind_next = KIND_NONE;
        need = walk_ofs(cls_kind) + {2'b0, rt_len_next} + W'(FCS_BYTES);
        if (cls_kind != KIND_NONE && {2'b0, pkt_len_next} >= need) begin
          region_next = L'({2'b0, pkt_len_next} - need);
          kind_next   = cls_kind;
          phase_next  = PH_ID;
        end
      end

      if ((kind_next == KIND_ASSOC_REQ || kind_next == KIND_PROBE_REQ ||
           kind_next == KIND_BEACON) &&
          {2'b0, p} == {2'b0, rt_len_next} + walk_ofs(kind_next)) begin
        kind_next  = KIND_WALK;
        phase_next = PH_ID;
      end

      if (kind_next == KIND_WALK) begin
        unique case (phase_next)
          PH_ID: begin
            if (region_next < L'(2)) begin
              kind_next = KIND_NONE;
            end else begin
              is_ssid_next = (data_byte == SSID_ID);
              region_next  = region_next - L'(1);
              phase_next   = PH_LEN;
            end
          end
          PH_LEN: begin
            region_next = region_next - L'(1);
            if (L'(data_byte) > region_next) begin
              kind_next = KIND_NONE;
            end else if (data_byte == 8'd0) begin
              phase_next = PH_ID;
            end else begin
              elem_rem_next = data_byte;
              phase_next    = PH_BODY;
            end
          end
          default: begin
            if (is_ssid_next) begin
              ob = SSID_FILL;
            end
            region_next   = region_next - L'(1);
            elem_rem_next = elem_rem_next - 8'd1;
            if (elem_rem_next == 8'd0) begin
              phase_next = PH_ID;
            end
          end
        endcase
      end

      m0 = ob;
      if ({2'b0, p} >= {2'b0, rt_len_next} + W'(ADDR_START)) begin
        r = p - rt_len_next;
        if (r[L-1:5] == '0) begin
          unique case (r[4:0])
            5'd4, 5'd16: begin
              all_ones_next = ff;
              m0 = data_byte;
            end
            5'd5, 5'd6, 5'd17, 5'd18: begin
              all_ones_next = all_ones_next & ff;
              m0 = data_byte;
            end
            5'd7, 5'd19: begin
              all_ones_next = all_ones_next & ff;
              held0_next    = data_byte;
              m0     = 8'd0;
              main_n = last_byte ? 2'd1 : 2'd0;
            end
            5'd8, 5'd20: begin
              all_ones_next = all_ones_next & ff;
              held1_next    = data_byte;
              m0     = 8'd0;
              main_n = last_byte ? 2'd2 : 2'd0;
            end
            5'd9, 5'd21: begin
              main_n = 2'd3;
              if (all_ones_next && ff) begin
                m0 = held0;
                m1 = held1;
                m2 = data_byte;
              end else begin
                m0 = 8'd0;
              end
            end
            5'd13, 5'd14, 5'd15: begin
              m0 = 8'd0;
            end
            default: begin
              m0 = ob;
            end
          endcase
        end
      end
      pos_next = p + L'(1);
    end

    if (last_byte) begin
      pos_next      = '0;
      kind_next     = KIND_NONE;
      phase_next    = PH_ID;
      all_ones_next = 1'b1;
    end

    grp.count    = n_pre + main_n;
    grp.pkt_last = last_byte;
    unique case (n_pre)
      2'd1:    grp.data = {8'd0, m0, 8'd0};
      2'd2:    grp.data = {m0, 8'd0, 8'd0};
      default: grp.data = {m2, m1, m0};
    endcase
  end

  assign push       = accept && (grp.count != 2'd0);
  assign push_group = grp;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      pkt_len  <= '0;
      rt_len   <= '0;
      kind     <= KIND_NONE;
      phase    <= PH_ID;
      is_ssid  <= 1'b0;
      elem_rem <= '0;
      region   <= '0;
      all_ones <= 1'b1;
    end else if (accept) begin
      pos      <= pos_next;
      pkt_len  <= pkt_len_next;
      rt_len   <= rt_len_next;
      kind     <= kind_next;
      phase    <= phase_next;
      is_ssid  <= is_ssid_next;
      elem_rem <= elem_rem_next;
      region   <= region_next;
      all_ones <= all_ones_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held0 <= held0_next;
      held1 <= held1_next;
    end
  end

endmodule

// File: rtl/core/wmfa_queue.sv
// ----------------------------------------------------------------------------
// wmfa_queue
// Small queue of output byte groups between the parser and the serializer.
// ----------------------------------------------------------------------------
module wmfa_queue import wmfa_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  group_t push_group,
  output logic   full,
  input  logic   pop,
  output group_t head,
  output logic   empty
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  group_t         mem [QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr, rd_ptr;
  logic [PW:0]    count;

  assign full  = (count == (PW+1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_group;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + (PW+1)'(1);
        2'b01:   count <= count - (PW+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// File: rtl/core/wmfa_back.sv
// ----------------------------------------------------------------------------
// wmfa_back
// Serializes each queued group into single output byte transfers.
// ----------------------------------------------------------------------------
module wmfa_back import wmfa_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  group_t     head,
  input  logic       empty,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last_of_packet,
  output logic       last_of_run
);

  logic [1:0] idx;
  logic       at_end;
  logic       take;

  assign out_valid          = !empty;
  assign at_end             = (idx == head.count - 2'd1);
  assign take               = out_valid && !out_stall;
  assign pop                = take && at_end;
  assign out_byte           = head.data[idx];
  assign last_of_run        = at_end;
  assign out_last_of_packet = at_end && head.pkt_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (take) begin
      idx <= at_end ? 2'd0 : idx + 2'd1;
    end
  end

endmodule

// File: rtl/core/wifi_mgmt_frame_anonymizer.sv
// ----------------------------------------------------------------------------
// wifi_mgmt_frame_anonymizer
// Streaming anonymizer for captured radiotap plus 802.11 packets.
// ----------------------------------------------------------------------------
// Bytes enter at one per cycle and leave at one per cycle. Each input byte
// causes zero to three output bytes: the last three bytes of the destination
// address and of the BSSID are held back until the sixth address byte has
// been checked for broadcast, then leave as a group of three. The parser
// places each group in a four-entry queue as the byte is accepted, and a
// serializer sends the queued bytes in order one byte per cycle, so input and
// output stall on their own; the input stalls only while the queue is full.
// There is no start-up delay after reset.
module wifi_mgmt_frame_anonymizer import wmfa_pkg::*; #(
  parameter int LENGTH_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        first_byte,
  input  logic        last_byte,
  input  logic [15:0] capture_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_last_of_packet,
  output logic        last_of_run
);

  logic   q_full;
  logic   q_empty;
  logic   push;
  logic   pop;
  group_t push_group;
  group_t head;

  wmfa_front #(
    .LENGTH_WIDTH(LENGTH_WIDTH)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .data_byte      (data_byte),
    .first_byte     (first_byte),
    .last_byte      (last_byte),
    .capture_length (capture_length),
    .q_full         (q_full),
    .push           (push),
    .push_group     (push_group)
  );

  wmfa_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_group (push_group),
    .full       (q_full),
    .pop        (pop),
    .head       (head),
    .empty      (q_empty)
  );

  wmfa_back u_back (
    .clk                (clk),
    .rst                (rst),
    .head               (head),
    .empty              (q_empty),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_byte           (out_byte),
    .out_last_of_packet (out_last_of_packet),
    .last_of_run        (last_of_run)
  );

endmodule

// File: rtl/core/wmfa_checker.sv
// ----------------------------------------------------------------------------
// wmfa_checker
// Port-level checks of the anonymizer, attached to the top level by bind.
// ----------------------------------------------------------------------------
module wmfa_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       out_last_of_packet,
  input logic       last_of_run
);

  // A stalled output transfer keeps its byte and flags.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_byte) &&
      $stable(out_last_of_packet) && $stable(last_of_run))
    else $error("stalled output changed");

  // The packet end is always the final byte of its group.
  a_last_in_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_last_of_packet |-> last_of_run)
    else $error("packet end inside a group");

  // Reset leaves nothing to send.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  // The input is held off only while queued output waits.
  a_stall_pending: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with nothing queued");

endmodule

bind wifi_mgmt_frame_anonymizer wmfa_checker u_wmfa_checker (
  .clk                (clk),
  .rst                (rst),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_byte           (out_byte),
  .out_last_of_packet (out_last_of_packet),
  .last_of_run        (last_of_run)
);
